// ----- rtl/szdd_pkg.sv -----
// shared types and constants for the zombie drop decider
`default_nettype none
package szdd_pkg;
    // zombie list length, a power of two so slot and alpha are plain bit slices
    localparam int ZOMBIES = 1024;

    localparam logic [1:0] VERDICT_ENQUEUE  = 2'd0;
    localparam logic [1:0] VERDICT_INVALID  = 2'd1;
    localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;
    localparam logic [1:0] VERDICT_ZAP      = 2'd3;

    localparam logic [1:0] REG_MAX_DROP  = 2'd0;
    localparam logic [1:0] REG_OVERWRITE = 2'd1;
    localparam logic [1:0] REG_MODE      = 2'd2;
    localparam logic [1:0] REG_CAPACITY  = 2'd3;

    localparam logic [1:0] MODE_SIMPLE = 2'd1;
    localparam logic [1:0] MODE_FULL   = 2'd2;

    localparam logic [16:0] PROB_ONE = 17'd65536;

    // start and finish of the shared serial divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/sred_zombie_drop_decider.sv -----
// top level of the zombie-list drop decider
//
// usage: one packet word in on s_*, one verdict word out on m_*, per packet.
// configuration words come in on cfg_*, only while the block is idle;
// cfg_index 0 peak drop prob, 1 overwrite prob, 2 drop mode, 3 capacity.
// steps: an invalid-flow or list-filling packet goes from the read state
// straight to the output register. a probing packet reads the zombie memory,
// then on a miss runs one serial division for the overwrite probability,
// then updates the ewma and the powers of h and runs at most one more
// division for the zap probability.
// one packet at a time; s_ready is high only in the idle state with cfg_valid low,
// so the next packet waits until the verdict is registered in the output.
// the output register holds its word while m_ready is low; a new packet can
// be accepted while it waits, and its result waits for the register to free.
// reset: fill count and hit frequency clear, registers take their defaults;
// zombie memory needs no clearing, since no slot is probed before the list
// has been filled once.
`default_nettype none
module sred_zombie_drop_decider (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_flow_valid,
    input  wire  [31:0] s_flow_id,
    input  wire  [15:0] s_queue_packets,
    input  wire  [31:0] s_now_time,
    input  wire  [9:0]  s_rand_index,
    input  wire  [15:0] s_rand_overwrite,
    input  wire  [15:0] s_rand_drop,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_verdict,
    output logic        m_hit,
    output logic [16:0] m_zap_probability,
    output logic [15:0] m_hit_freq_out
);
    import szdd_pkg::*;

    localparam int AW = $clog2(ZOMBIES);
    localparam int FW = $clog2(ZOMBIES + 1);
    localparam logic [FW-1:0] FULL = FW'(ZOMBIES);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_READ   = 4'd1;
    localparam logic [3:0] ST_OWDIV  = 4'd2;
    localparam logic [3:0] ST_EWMA   = 4'd3;
    localparam logic [3:0] ST_H2     = 4'd4;
    localparam logic [3:0] ST_H3     = 4'd5;
    localparam logic [3:0] ST_NUMDIV = 4'd6;
    localparam logic [3:0] ST_NUM2   = 4'd7;
    localparam logic [3:0] ST_ZDIV   = 4'd8;
    localparam logic [3:0] ST_DECIDE = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    // configuration registers
    logic [15:0] pmax_reg, pow_reg, cap_reg;
    logic [1:0]  mode_reg;

    logic [3:0]  state_reg, state_next;
    logic [FW-1:0] fill_reg;
    logic [31:0] hf_reg;

    // captured packet
    logic        fv_reg;
    logic [31:0] flow_reg, now_reg;
    logic [15:0] q_reg, rov_reg, rdrop_reg;
    logic [AW-1:0] slot_reg;

    // working values
    logic        hit_reg;
    logic [16:0] base_reg;
    logic [15:0] h_reg;
    logic [47:0] hpow_reg;
    logic [63:0] num_reg;
    logic [16:0] pz_reg;

    // output register
    logic        ovalid_reg;
    logic [1:0]  overd_reg;
    logic        ohit_reg;
    logic [16:0] opz_reg;
    logic [15:0] ohf_reg;

    logic [AW-1:0] rd_addr;
    logic [31:0] rd_flow, rd_stamp;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    div_req_t    dreq;
    div_rsp_t    drsp;

    // while idle the memory follows the offered slot, so the probed entry
    // is already on rd_flow/rd_stamp in the read state
    assign rd_addr = (state_reg == ST_IDLE) ? s_rand_index[AW-1:0] : slot_reg;

    szdd_zombie_mem #(.AW(AW)) u_mem (
        .aclk     (aclk),
        .rd_addr  (rd_addr),
        .rd_flow  (rd_flow),
        .rd_stamp (rd_stamp),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_flow  (flow_reg),
        .wr_stamp (now_reg)
    );

    szdd_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;

    wire s_acc  = s_valid && s_ready;
    wire filling = (fill_reg < FULL);

    // base probability from occupancy thirds and sixths
    logic [17:0] q3, q6;
    logic [16:0] base_c;
    always_comb begin
        q3 = 18'(q_reg) * 18'd3;
        q6 = 18'(q_reg) * 18'd6;
        priority if (q3 >= 18'(cap_reg) && q_reg <= cap_reg)
            base_c = 17'(pmax_reg);
        else if (q6 >= 18'(cap_reg) && q3 < 18'(cap_reg))
            base_c = 17'(pmax_reg >> 2);
        else
            base_c = '0;
    end

    // ewma update of the hit frequency
    logic [47:0] hf_dec;
    logic [32:0] hf_new;
    always_comb begin
        hf_dec = (48'(hf_reg) * 48'(pow_reg)) >> (AW + 16);
        hf_new = 33'(hf_reg) - 33'(hf_dec)
               + (hit_reg ? 33'((48'(pow_reg) << 16) >> AW) : 33'd0);
    end

    wire [16:0] h_plus = 17'(h_reg) + 17'd65536;
    wire [33:0] base_hp = 34'(base_reg) * 34'(h_plus);
    wire [63:0] base_sh = 64'(base_reg) << 24;

    // zombie list write enable and address: fill, overwrite on a miss, stamp on a hit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        if (state_reg == ST_READ && fv_reg && filling) begin
            wr_en   = 1'b1;
            wr_addr = fill_reg[AW-1:0];
        end else if (state_reg == ST_OWDIV && drsp.done
                     && 64'(rov_reg) < drsp.quotient) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_READ && fv_reg && !filling
                     && rd_flow == flow_reg) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = 64'd1;
        unique case (state_reg)
            ST_IDLE: if (s_acc) state_next = ST_READ;
            ST_READ: begin
                if (!fv_reg || filling) begin
                    state_next = ST_OUT;
                end else if (rd_flow == flow_reg) begin
                    state_next = ST_EWMA;
                end else begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(pow_reg) << 10;
                    dreq.divisor  = 64'd1024 + 64'(rd_stamp);
                    state_next    = ST_OWDIV;
                end
            end
            ST_OWDIV: if (drsp.done) state_next = ST_EWMA;
            ST_EWMA:  state_next = ST_H2;
            ST_H2:    state_next = ST_H3;
            ST_H3: begin
                // hpow holds h*h here
                if (mode_reg == MODE_SIMPLE && h_reg > 16'd4096) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = base_sh;
                    dreq.divisor  = 64'(hpow_reg);
                    state_next    = ST_ZDIV;
                end else if (mode_reg == MODE_FULL && base_reg != '0
                             && h_reg > 16'd4096) begin
                    state_next = ST_NUMDIV;
                end else if (mode_reg == MODE_FULL && base_reg != '0
                             && h_reg != '0) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'(base_hp);
                    dreq.divisor  = 64'(h_reg);
                    state_next    = ST_ZDIV;
                end else begin
                    state_next = ST_DECIDE;
                end
            end
            ST_NUMDIV: state_next = ST_NUM2;
            ST_NUM2: begin
                // hpow now h^3
                dreq.start    = 1'b1;
                dreq.dividend = num_reg;
                dreq.divisor  = 64'(hpow_reg);
                state_next    = ST_ZDIV;
            end
            ST_ZDIV:   if (drsp.done) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:    if (!ovalid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            hf_reg     <= '0;
            ovalid_reg <= 1'b0;
            pmax_reg   <= 16'd9830;
            pow_reg    <= 16'd16384;
            mode_reg   <= MODE_SIMPLE;
            cap_reg    <= 16'd25;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_MAX_DROP:  pmax_reg <= cfg_data;
                    REG_OVERWRITE: pow_reg  <= cfg_data;
                    REG_MODE:      mode_reg <= cfg_data[1:0];
                    REG_CAPACITY:  cap_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_READ && fv_reg && filling)
                fill_reg <= fill_reg + FW'(1);
            if (state_reg == ST_EWMA)
                hf_reg <= hf_new[32] ? 32'hFFFF_FFFF : hf_new[31:0];
            // a new word replaces a taken one in the same cycle
            if (state_reg == ST_OUT && (!ovalid_reg || m_ready))
                ovalid_reg <= 1'b1;
            else if (m_valid && m_ready)
                ovalid_reg <= 1'b0;
        end
        if (s_acc) begin
            fv_reg    <= s_flow_valid;
            flow_reg  <= s_flow_id;
            q_reg     <= s_queue_packets;
            now_reg   <= s_now_time;
            slot_reg  <= s_rand_index[AW-1:0];
            rov_reg   <= s_rand_overwrite;
            rdrop_reg <= s_rand_drop;
            hit_reg   <= 1'b0;
            pz_reg    <= '0;
        end
        if (state_reg == ST_READ)
            hit_reg <= fv_reg && !filling && (rd_flow == flow_reg);
        if (state_reg == ST_EWMA) begin
            base_reg <= base_c;
            h_reg    <= hf_new[32] ? 16'hFFFF : hf_new[31:16];
        end
        if (state_reg == ST_H2)
            hpow_reg <= 48'(h_reg) * 48'(h_reg);
        if (state_reg == ST_H3) begin
            // preset zap probability for the cases without a division
            if (mode_reg == MODE_SIMPLE)
                pz_reg <= base_reg > PROB_ONE ? PROB_ONE : base_reg;
            else if (mode_reg == MODE_FULL && base_reg != '0 && h_reg == '0)
                pz_reg <= PROB_ONE;
            else
                pz_reg <= '0;
        end
        if (state_reg == ST_NUMDIV) begin
            num_reg  <= 64'(base_hp) << 24;
            hpow_reg <= 48'(hpow_reg[31:0]) * 48'(h_reg);
        end
        if (state_reg == ST_ZDIV && drsp.done)
            pz_reg <= drsp.quotient > 64'(PROB_ONE) ? PROB_ONE : drsp.quotient[16:0];
        if (state_reg == ST_OUT && (!ovalid_reg || m_ready)) begin
            ohit_reg <= hit_reg;
            opz_reg  <= pz_reg;
            ohf_reg  <= hf_reg[31:16];
            if (!fv_reg)
                overd_reg <= VERDICT_INVALID;
            else if (pz_reg != '0 && 17'(rdrop_reg) < pz_reg)
                overd_reg <= VERDICT_ZAP;
            else if (17'(q_reg) + 17'd1 <= 17'(cap_reg))
                overd_reg <= VERDICT_ENQUEUE;
            else
                overd_reg <= VERDICT_OVERFLOW;
        end
    end

    assign m_valid           = ovalid_reg;
    assign m_verdict         = overd_reg;
    assign m_hit             = ohit_reg;
    assign m_zap_probability = opz_reg;
    assign m_hit_freq_out    = ohf_reg;

    // a packet is taken only while idle
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> state_reg == ST_IDLE)
        else $error("packet accepted outside idle");

    // fill count never passes the list size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL)
        else $error("fill count overrun");

    // zap probability is at most one
    a_pz_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_zap_probability <= PROB_ONE)
        else $error("zap probability above one");
endmodule
`default_nettype wire

// ----- rtl/szdd_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module szdd_divider (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  szdd_pkg::div_req_t       req,
    output szdd_pkg::div_rsp_t       rsp
);
    import szdd_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dsr_reg};
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one bit, subtract when it fits
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ----- rtl/szdd_zombie_mem.sv -----
// zombie list storage: flow and stamp, one write and one registered read
`default_nettype none
module szdd_zombie_mem #(
    parameter int AW = 10
) (
    input  wire           aclk,
    input  wire [AW-1:0]  rd_addr,
    output logic [31:0]   rd_flow,
    output logic [31:0]   rd_stamp,
    input  wire           wr_en,
    input  wire [AW-1:0]  wr_addr,
    input  wire [31:0]    wr_flow,
    input  wire [31:0]    wr_stamp
);
    logic [63:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_flow, wr_stamp};
        end
        {rd_flow, rd_stamp} <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- sim/tb_sred_zombie_drop_decider.sv -----
// self-checking testbench for the zombie-list drop decider
`timescale 1ns / 1ps
module tb_sred_zombie_drop_decider;
    import szdd_pkg::*;

    localparam int NUM_ZOMBIES = ZOMBIES;
    localparam int CYCLE_LIMIT = 3000000;
    // a probing packet runs up to two serial divisions, so allow plenty
    localparam int SETTLE_CYCLES = 400;

    // one packet word as driven on s_*
    typedef struct packed {
        logic        flow_valid;
        logic [31:0] flow_id;
        logic [15:0] queue_packets;
        logic [31:0] now_time;
        logic [9:0]  rand_index;
        logic [15:0] rand_overwrite;
        logic [15:0] rand_drop;
    } packet_t;

    // one verdict word as seen on m_*
    typedef struct packed {
        logic [1:0]  verdict;
        logic        hit;
        logic [16:0] zap_probability;
        logic [15:0] hit_freq_out;
    } decision_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_flow_valid;
    logic [31:0] s_flow_id;
    logic [15:0] s_queue_packets;
    logic [31:0] s_now_time;
    logic [9:0]  s_rand_index;
    logic [15:0] s_rand_overwrite;
    logic [15:0] s_rand_drop;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_verdict;
    logic        m_hit;
    logic [16:0] m_zap_probability;
    logic [15:0] m_hit_freq_out;

    sred_zombie_drop_decider uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_flow_valid      (s_flow_valid),
        .s_flow_id         (s_flow_id),
        .s_queue_packets   (s_queue_packets),
        .s_now_time        (s_now_time),
        .s_rand_index      (s_rand_index),
        .s_rand_overwrite  (s_rand_overwrite),
        .s_rand_drop       (s_rand_drop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_verdict         (m_verdict),
        .m_hit             (m_hit),
        .m_zap_probability (m_zap_probability),
        .m_hit_freq_out    (m_hit_freq_out)
    );

    // shadow copy of the block's state and registers
    logic [31:0] zombie_flow_copy  [NUM_ZOMBIES];
    logic [31:0] zombie_stamp_copy [NUM_ZOMBIES];
    int unsigned zombie_count;
    logic [31:0] hit_freq_copy;
    logic [15:0] peak_prob_reg;
    logic [15:0] overwrite_prob_reg;
    logic [1:0]  mode_reg;
    logic [15:0] capacity_reg;

    decision_t   pending_decisions[$];
    int          error_count;
    int unsigned cycle_count;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    // a few flows shared by many packets, so probes find hits
    logic [31:0] flow_pool[4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678, 32'hA5A5_5A5A};

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // clamp to probability one
    function automatic logic [63:0] clamp_prob(input logic [63:0] p);
        return (p > 64'd65536) ? 64'd65536 : p;
    endfunction

    // occupancy bands: upper two thirds give the peak, the sixth below a quarter of it
    function automatic logic [63:0] occupancy_prob(input logic [63:0] q, input logic [63:0] cap);
        if (3 * q >= cap && q <= cap) return 64'(peak_prob_reg);
        if (6 * q >= cap && 3 * q < cap) return 64'(peak_prob_reg >> 2);
        return 64'd0;
    endfunction

    function automatic logic [63:0] scaled_zap_prob(input logic [63:0] base);
        logic [63:0] h;
        h = 64'(hit_freq_copy >> 16);
        if (mode_reg == MODE_SIMPLE) begin
            if (h > 64'd4096) return clamp_prob((base << 24) / (h * h));
            return clamp_prob(base);
        end
        if (mode_reg == MODE_FULL) begin
            if (base == 0) return 64'd0;
            // no hits yet means an unbounded factor
            if (h == 0) return 64'd65536;
            if (h > 64'd4096) return clamp_prob(((base << 24) * (h + 64'd65536)) / (h * h * h));
            return clamp_prob((base * (h + 64'd65536)) / h);
        end
        return 64'd0;
    endfunction

    // works out the verdict word for one packet and advances the shadow state
    function automatic decision_t decide_packet(input packet_t p);
        decision_t   d;
        int unsigned slot;
        logic [63:0] hf;
        logic [63:0] pow;
        logic [63:0] peff;
        logic [63:0] pz;
        logic [63:0] q;
        logic [63:0] cap;
        d = '0;
        q = 64'(p.queue_packets);
        cap = 64'(capacity_reg);
        pz = 0;
        if (!p.flow_valid) begin
            d.verdict = VERDICT_INVALID;
        end else if (zombie_count < NUM_ZOMBIES) begin
            zombie_flow_copy[zombie_count] = p.flow_id;
            zombie_stamp_copy[zombie_count] = p.now_time;
            zombie_count++;
            d.verdict = (q + 1 <= cap) ? VERDICT_ENQUEUE : VERDICT_OVERFLOW;
        end else begin
            slot = p.rand_index % NUM_ZOMBIES;
            pow = 64'(overwrite_prob_reg);
            hf = 64'(hit_freq_copy);
            if (zombie_flow_copy[slot] == p.flow_id) begin
                d.hit = 1'b1;
                zombie_stamp_copy[slot] = p.now_time;
            end else begin
                peff = (pow * 1024) / (64'd1024 + 64'(zombie_stamp_copy[slot]));
                if (64'(p.rand_overwrite) < peff) begin
                    zombie_flow_copy[slot] = p.flow_id;
                    zombie_stamp_copy[slot] = p.now_time;
                end
            end
            // ewma with alpha = overwrite prob / zombies
            hf = hf - (hf * pow) / (64'(NUM_ZOMBIES) * 64'd65536);
            if (d.hit) hf = hf + (pow << 16) / 64'(NUM_ZOMBIES);
            if (hf > 64'hFFFF_FFFF) hf = 64'hFFFF_FFFF;
            hit_freq_copy = hf[31:0];
            pz = scaled_zap_prob(occupancy_prob(q, cap));
            if (64'(p.rand_drop) < pz) d.verdict = VERDICT_ZAP;
            else d.verdict = (q < cap) ? VERDICT_ENQUEUE : VERDICT_OVERFLOW;
        end
        d.zap_probability = pz[16:0];
        d.hit_freq_out = hit_freq_copy[31:16];
        return d;
    endfunction

    // predict at every accepted word, check every delivered word
    always @(posedge aclk) begin
        decision_t want;
        packet_t   p;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_DROP:  peak_prob_reg = cfg_data;
                    REG_OVERWRITE: overwrite_prob_reg = cfg_data;
                    REG_MODE:      mode_reg = cfg_data[1:0];
                    REG_CAPACITY:  capacity_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                p = '{s_flow_valid, s_flow_id, s_queue_packets, s_now_time,
                      s_rand_index, s_rand_overwrite, s_rand_drop};
                pending_decisions = {pending_decisions, decide_packet(p)};
            end
            if (m_valid && m_ready) begin
                if (pending_decisions.size() == 0) begin
                    $error("verdict word with nothing outstanding");
                    error_count++;
                end else begin
                    want = pending_decisions.pop_front();
                    if (m_verdict !== want.verdict) begin
                        $error("verdict: expected %0d, got %0d", want.verdict, m_verdict);
                        error_count++;
                    end
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, m_hit);
                        error_count++;
                    end
                    if (m_zap_probability !== want.zap_probability) begin
                        $error("zap_probability: expected %0d, got %0d",
                               want.zap_probability, m_zap_probability);
                        error_count++;
                    end
                    if (m_hit_freq_out !== want.hit_freq_out) begin
                        $error("hit_freq_out: expected %0d, got %0d",
                               want.hit_freq_out, m_hit_freq_out);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // send one packet word, idling first at the sender's rate
    task automatic send_packet(input packet_t p);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        {s_flow_valid, s_flow_id, s_queue_packets, s_now_time,
         s_rand_index, s_rand_overwrite, s_rand_drop} <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // let every outstanding word come back, then give the block time to settle
    task automatic drain_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [15:0] pmax, input logic [15:0] pow,
                                 input logic [1:0] mode, input logic [15:0] cap);
        drain_block();
        write_register(REG_MAX_DROP, pmax);
        write_register(REG_OVERWRITE, pow);
        write_register(REG_MODE, mode);
        write_register(REG_CAPACITY, cap);
    endtask

    // random packet: mostly pooled flows and occupancies up to just past the capacity
    function automatic packet_t random_packet();
        packet_t p;
        int unsigned top;
        p.flow_valid = ($urandom_range(99) < 92);
        p.flow_id = ($urandom_range(99) < 75) ? flow_pool[$urandom_range(3)] : $urandom;
        top = (capacity_reg < 16'hFFFD) ? capacity_reg + 2 : 16'hFFFF;
        p.queue_packets = ($urandom_range(99) < 70) ? 16'($urandom_range(top)) : 16'($urandom);
        p.now_time = ($urandom_range(99) < 70) ? $urandom_range(4000) : $urandom;
        p.rand_index = 10'($urandom);
        p.rand_overwrite = 16'($urandom);
        p.rand_drop = 16'($urandom);
        return p;
    endfunction

    // extremes of every field while the list is still filling
    task automatic test_fill_extremes();
        send_packet('{1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF, 16'hFFFF});
        send_packet('{1'b1, 32'hFFFF_FFFF, 16'd0, 32'd0, 10'd0, 16'd0, 16'd0});
        send_packet('{1'b1, 32'd0, 16'd24, 32'hFFFF_FFFF, 10'h3FF, 16'hFFFF, 16'hFFFF});
        send_packet('{1'b1, 32'h1234_5678, 16'd25, 32'd1, 10'd1, 16'd1, 16'd1});
        send_packet('{1'b1, 32'hA5A5_5A5A, 16'hFFFF, 32'd2, 10'd512, 16'h8000, 16'h8000});
        send_packet('{1'b0, 32'd0, 16'd0, 32'd0, 10'd0, 16'd0, 16'd0});
    endtask

    // fill the list up to its last slot, which the directed probe test fills
    task automatic test_fill_list();
        packet_t p;
        while (zombie_count < NUM_ZOMBIES - 1) begin
            p = random_packet();
            send_packet(p);
        end
        drain_block();
    endtask

    // first probes: zero hit frequency in full mode, slot extremes
    task automatic test_probe_directed();
        set_registers(16'd30000, 16'hFFFF, MODE_FULL, 16'd30);
        // last filling packet
        send_packet('{1'b1, flow_pool[0], 16'd10, 32'd5, 10'd0, 16'd0, 16'd0});
        send_packet('{1'b1, flow_pool[0], 16'd20, 32'd6, 10'h3FF, 16'd0, 16'd0});
        send_packet('{1'b1, 32'hDEAD_BEEF, 16'd6, 32'd7, 10'd0, 16'd0, 16'hFFFF});
        send_packet('{1'b1, 32'hDEAD_BEEF, 16'd1, 32'd8, 10'd0, 16'hFFFF, 16'd0});
        send_packet('{1'b1, flow_pool[1], 16'd31, 32'hFFFF_FFFF, 10'd512, 16'd0, 16'd0});
        send_packet('{1'b0, flow_pool[1], 16'd15, 32'd9, 10'd5, 16'd0, 16'd0});
    endtask

    task automatic test_random_phase(input int count, input bit hold_off);
        packet_t p;
        for (int i = 0; i < count; i++) begin
            // let the block empty out completely now and then
            if (hold_off && (i % 25 == 0)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending_decisions.size() != 0) @(posedge aclk);
            end
            p = random_packet();
            send_packet(p);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_DROP;
        cfg_data = '0;
        s_valid = 1'b0;
        {s_flow_valid, s_flow_id, s_queue_packets, s_now_time,
         s_rand_index, s_rand_overwrite, s_rand_drop} = '0;
        m_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        sender_idle_pct = 31;
        receiver_idle_pct = 87;
        zombie_count = 0;
        hit_freq_copy = '0;
        peak_prob_reg = 16'd9830;
        overwrite_prob_reg = 16'd16384;
        mode_reg = MODE_SIMPLE;
        capacity_reg = 16'd25;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_fill_extremes();
        test_fill_list();
        test_probe_directed();
        test_random_phase(100, 1'b0);

        sender_idle_pct = 87;
        receiver_idle_pct = 31;
        set_registers(16'd9830, 16'd16384, MODE_SIMPLE, 16'd25);
        test_random_phase(150, 1'b1);
        set_registers(16'hFFFF, 16'hFFFF, MODE_SIMPLE, 16'hFFFF);
        test_random_phase(80, 1'b0);
        set_registers(16'd0, 16'd0, 2'd0, 16'd1);
        test_random_phase(60, 1'b0);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        set_registers(16'd40000, 16'hFFFF, 2'd3, 16'd0);
        test_random_phase(40, 1'b0);
        set_registers(16'hFFFF, 16'hFFFF, MODE_FULL, 16'd40);
        test_random_phase(200, 1'b0);
        set_registers(16'd20000, 16'd30000, MODE_SIMPLE, 16'd12);
        test_random_phase(100, 1'b0);

        drain_block();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
